>>> rtl/amp_telemetry_calibration_swr_top_macros.svh
// Assertion macros for the amplifier telemetry calibration block.
// Users provide clk_i and rst_ni in the module that expands them.
`ifndef AMP_TELEMETRY_CALIBRATION_SWR_TOP_MACROS_SVH
`define AMP_TELEMETRY_CALIBRATION_SWR_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define ATC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ATC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ATC_ASSERT_IMPL(lbl, ante, cons)
`define ATC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> rtl/atcswr_pkg.sv
// Shared types and calibration constants for the telemetry calibration block.
// No dependencies.
package atcswr_pkg;

  localparam int RAW_BITS_DEF        = 10;
  localparam int POWER_FRAC_BITS_DEF = 3;

  // Quadratic fits per power lane: forward, reflected, drive. Units of 2^-32.
  localparam int NUM_LANES = 3;
  localparam longint FIT_A [NUM_LANES] = '{64'sd19382398, 64'sd21620634, 64'sd3443989};
  localparam longint FIT_B [NUM_LANES] = '{-64'sd750665732, -64'sd399159548, 64'sd685104727};
  localparam longint FIT_C [NUM_LANES] =
    '{64'sd110343775833, 64'sd10453021655, 64'sd4313506689};

  localparam longint CUR_GAIN   = 64'sd1740735551;
  localparam longint CUR_OFFSET = 64'sd1309601951;
  localparam int     CUR_SHIFT  = 28;

  localparam logic [15:0] POWER_MAX   = 16'hFFFF;
  localparam logic [15:0] CURRENT_MAX = 16'd8191;

  localparam logic [15:0] SWR_ONE = 16'd256;
  localparam logic [15:0] SWR_CAP = 16'd50944;
  // Reflection cap: refl * RHO_REFL_K >= fwd * RHO_FWD_K.
  localparam logic [13:0] RHO_REFL_K = 14'd10000;
  localparam logic [13:0] RHO_FWD_K  = 14'd9801;

  typedef struct packed {
    logic [15:0] fwd;
    logic [15:0] refl;
    logic [12:0] cur;
    logic [15:0] drv;
  } res_t;

endpackage

>>> rtl/atcswr_ratio.sv
// SWR pipeline: bit-per-stage divide, square root and final divide.
// Depends on atcswr_pkg and the assertion macro header.
`include "amp_telemetry_calibration_swr_top_macros.svh"
module atcswr_ratio import atcswr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  res_t        res_i,
  output logic        valid_o,
  output res_t        res_o,
  output logic [15:0] swr_o
);

  localparam int QB = 32;
  localparam int RB = 16;
  localparam int SB = 16;

  typedef struct packed {
    logic zero;
    logic cap;
    res_t res;
  } tag_t;

  // Entry stage: special cases and divider setup.
  logic        v1_q [QB+1];
  tag_t        t1_q [QB+1];
  logic [15:0] r1_q [QB+1];
  logic [QB-1:0] q1_q [QB+1];

  logic zero_d, cap_d;
  assign zero_d = (res_i.fwd == '0) || (res_i.refl == '0);
  assign cap_d  = (30'(res_i.refl) * 30'(RHO_REFL_K)) >= (30'(res_i.fwd) * 30'(RHO_FWD_K));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q[0] <= 1'b0;
    end else if (en_i) begin
      v1_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t1_q[0] <= '{zero: zero_d, cap: cap_d, res: res_i};
      r1_q[0] <= (zero_d || cap_d) ? 16'd0 : res_i.refl;
      q1_q[0] <= '0;
    end
  end

  // Restoring division refl * 2^32 / fwd, one quotient bit per stage.
  for (genvar i = 1; i <= QB; i++) begin : g_div1
    logic [16:0] sh;
    logic [16:0] dv;
    logic        ge;
    assign sh = {r1_q[i-1], 1'b0};
    assign dv = {1'b0, t1_q[i-1].res.fwd};
    assign ge = sh >= dv;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v1_q[i] <= 1'b0;
      end else if (en_i) begin
        v1_q[i] <= v1_q[i-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        t1_q[i] <= t1_q[i-1];
        r1_q[i] <= ge ? 16'(sh - dv) : sh[15:0];
        q1_q[i] <= {q1_q[i-1][QB-2:0], ge};
      end
    end
  end

  // Digit-by-digit square root of the quotient, one root bit per stage.
  logic        v2_q    [1:RB];
  tag_t        t2_q    [1:RB];
  logic [16:0] rem2_q  [1:RB];
  logic [15:0] root2_q [1:RB];
  logic [QB-1:0] q2_q  [1:RB];

  for (genvar j = 1; j <= RB; j++) begin : g_sqrt
    logic          src_v;
    tag_t          src_t;
    logic [16:0]   src_rem;
    logic [15:0]   src_root;
    logic [QB-1:0] src_q;
    logic [18:0]   rt;
    logic [18:0]   trial;
    logic          ge;

    if (j == 1) begin : g_first
      assign src_v    = v1_q[QB];
      assign src_t    = t1_q[QB];
      assign src_rem  = '0;
      assign src_root = '0;
      assign src_q    = q1_q[QB];
    end else begin : g_next
      assign src_v    = v2_q[j-1];
      assign src_t    = t2_q[j-1];
      assign src_rem  = rem2_q[j-1];
      assign src_root = root2_q[j-1];
      assign src_q    = q2_q[j-1];
    end

    assign rt    = {src_rem, src_q[QB-1:QB-2]};
    assign trial = {1'b0, src_root, 2'b01};
    assign ge    = rt >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v2_q[j] <= 1'b0;
      end else if (en_i) begin
        v2_q[j] <= src_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        t2_q[j]    <= src_t;
        rem2_q[j]  <= ge ? 17'(rt - trial) : rt[16:0];
        root2_q[j] <= {src_root[14:0], ge};
        q2_q[j]    <= {src_q[QB-3:0], 2'b00};
      end
    end
  end

  // Setup of the rounded ratio (512*num + den) / (2*den).
  logic        p_vld_q;
  tag_t        p_tag_q;
  logic [17:0] p_rem_q;
  logic [15:0] p_n_q;
  logic [17:0] p_d_q;

  logic [15:0] rho;
  logic [16:0] den;
  logic [26:0] num_n;
  assign rho   = (t2_q[RB].zero || t2_q[RB].cap) ? 16'd0 : root2_q[RB];
  assign den   = 17'h10000 - {1'b0, rho};
  assign num_n = 27'({1'b1, rho, 9'b0}) + 27'(den);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
    end else if (en_i) begin
      p_vld_q <= v2_q[RB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_tag_q <= t2_q[RB];
      p_rem_q <= 18'(num_n[26:16]);
      p_n_q   <= num_n[15:0];
      p_d_q   <= {den, 1'b0};
    end
  end

  logic        v3_q [1:SB];
  tag_t        t3_q [1:SB];
  logic [17:0] rem3_q [1:SB];
  logic [15:0] n3_q [1:SB];
  logic [17:0] d3_q [1:SB];
  logic [15:0] s3_q [1:SB];

  for (genvar k = 1; k <= SB; k++) begin : g_div2
    logic        src_v;
    tag_t        src_t;
    logic [17:0] src_rem;
    logic [15:0] src_n;
    logic [17:0] src_d;
    logic [15:0] src_s;
    logic [18:0] tt;
    logic [18:0] dd;
    logic        ge;

    if (k == 1) begin : g_first
      assign src_v   = p_vld_q;
      assign src_t   = p_tag_q;
      assign src_rem = p_rem_q;
      assign src_n   = p_n_q;
      assign src_d   = p_d_q;
      assign src_s   = '0;
    end else begin : g_next
      assign src_v   = v3_q[k-1];
      assign src_t   = t3_q[k-1];
      assign src_rem = rem3_q[k-1];
      assign src_n   = n3_q[k-1];
      assign src_d   = d3_q[k-1];
      assign src_s   = s3_q[k-1];
    end

    assign tt = {src_rem, src_n[15]};
    assign dd = {1'b0, src_d};
    assign ge = tt >= dd;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v3_q[k] <= 1'b0;
      end else if (en_i) begin
        v3_q[k] <= src_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        t3_q[k]   <= src_t;
        rem3_q[k] <= ge ? 18'(tt - dd) : tt[17:0];
        n3_q[k]   <= {src_n[14:0], 1'b0};
        d3_q[k]   <= src_d;
        s3_q[k]   <= {src_s[14:0], ge};
      end
    end
  end

  // Output register.
  logic        o_vld_q;
  res_t        o_res_q;
  logic [15:0] o_swr_q;
  logic [15:0] swr_d;

  always_comb begin
    if (t3_q[SB].zero) begin
      swr_d = SWR_ONE;
    end else if (t3_q[SB].cap || (s3_q[SB] > SWR_CAP)) begin
      swr_d = SWR_CAP;
    end else begin
      swr_d = s3_q[SB];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_vld_q <= 1'b0;
    end else if (en_i) begin
      o_vld_q <= v3_q[SB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      o_res_q <= t3_q[SB].res;
      o_swr_q <= swr_d;
    end
  end

  assign valid_o = o_vld_q;
  assign res_o   = o_res_q;
  assign swr_o   = o_swr_q;

  `ATC_ASSERT_IMPL(a_swr_range, valid_o, (swr_o >= SWR_ONE) && (swr_o <= SWR_CAP))
  `ATC_ASSERT_IMPL(a_swr_no_carrier, valid_o && ((res_o.fwd == '0) || (res_o.refl == '0)),
                   swr_o == SWR_ONE)
  `ATC_ASSERT_IMPL(a_swr_full_refl, valid_o && (res_o.fwd != '0) && (res_o.refl >= res_o.fwd),
                   swr_o == SWR_CAP)
  `ATC_ASSERT_NEXT(a_stall_keeps, valid_o && !en_i, valid_o)

endmodule

>>> rtl/amp_telemetry_calibration_swr_top.sv
// Amplifier telemetry calibration: three power lanes, current lane, SWR pipeline.
// Depends on atcswr_pkg and atcswr_ratio.
//
// Takes one telemetry frame per transaction and returns one result per frame, in order.
// A new frame is accepted every clock cycle unless the output stalls. From acceptance to
// the output, a frame passes three stages of power and current calibration, then a
// bit-per-stage pipeline for the SWR (a 32-stage divider, a 16-stage square root and a
// 16-stage rounding divider, plus entry, setup and output registers). The whole pipeline
// advances only when the output register is empty or being taken, so a stalled output
// holds every frame in place. There is no configuration and no state between frames.
module amp_telemetry_calibration_swr_top import atcswr_pkg::*; #(
  parameter int RAW_BITS        = RAW_BITS_DEF,
  parameter int POWER_FRAC_BITS = POWER_FRAC_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [RAW_BITS-1:0] forward_raw_i,
  input  logic [RAW_BITS-1:0] reflected_raw_i,
  input  logic [RAW_BITS-1:0] current_raw_i,
  input  logic [RAW_BITS-1:0] drive_raw_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [15:0]         forward_power_o,
  output logic [15:0]         reflected_power_o,
  output logic [12:0]         supply_current_o,
  output logic [15:0]         drive_power_o,
  output logic [15:0]         swr_ratio_o
);

  localparam int VW        = 2 * RAW_BITS + 28;
  localparam int POW_SHIFT = 32 - POWER_FRAC_BITS;

  function automatic logic [15:0] round_sat(input logic signed [VW-1:0] v, input int sh,
                                            input logic [15:0] maxv);
    logic [VW-1:0] t;
    logic [VW-1:0] q;
    begin
      t = $unsigned(v) + (VW'(1) << (sh - 1));
      q = t >> sh;
      if (v <= 0) begin
        return 16'd0;
      end else if (q > VW'(maxv)) begin
        return maxv;
      end else begin
        return q[15:0];
      end
    end
  endfunction

  logic en;
  logic swr_valid;

  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  logic pv1_q, pv2_q, pv3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv1_q <= 1'b0;
      pv2_q <= 1'b0;
      pv3_q <= 1'b0;
    end else if (en) begin
      pv1_q <= in_valid_i;
      pv2_q <= pv1_q;
      pv3_q <= pv2_q;
    end
  end

  logic [RAW_BITS-1:0] raw_lane [NUM_LANES];
  logic [15:0]         pw_q     [NUM_LANES];

  assign raw_lane[0] = forward_raw_i;
  assign raw_lane[1] = reflected_raw_i;
  assign raw_lane[2] = drive_raw_i;

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    localparam bit     HAS_TAPER = FIT_B[l] < 0;
    localparam longint SLOPE     = HAS_TAPER ?
      (FIT_B[l] / 2 + (2 * FIT_A[l] * FIT_C[l]) / (-FIT_B[l])) : 64'sd0;
    // First raw count at or past the vertex of the curve.
    localparam longint VERTEX    = HAS_TAPER ?
      ((-FIT_B[l] + 2 * FIT_A[l] - 1) / (2 * FIT_A[l])) : 64'sd0;

    logic signed [VW-1:0] rs;
    logic signed [VW-1:0] sq_q, br_q, sr_q, v_q;
    logic                 tap_q, zero_q;
    logic signed [VW-1:0] quad;

    assign rs   = VW'($signed({1'b0, raw_lane[l]}));
    assign quad = VW'(FIT_A[l]) * sq_q + br_q + VW'(FIT_C[l]);

    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_q   <= rs * rs;
        br_q   <= rs * VW'(FIT_B[l]);
        sr_q   <= rs * VW'(SLOPE);
        tap_q  <= HAS_TAPER && (rs < VW'(VERTEX));
        zero_q <= raw_lane[l] == '0;
        if (zero_q) begin
          v_q <= '0;
        end else if (tap_q) begin
          v_q <= sr_q;
        end else begin
          v_q <= quad;
        end
        pw_q[l] <= round_sat(v_q, POW_SHIFT, POWER_MAX);
      end
    end
  end

  logic signed [VW-1:0] cg_q, cv_q;
  logic [12:0]          cur_q;
  logic [15:0]          cur_full;

  assign cur_full = round_sat(cv_q, CUR_SHIFT, CURRENT_MAX);

  always_ff @(posedge clk_i) begin
    if (en) begin
      cg_q  <= VW'($signed({1'b0, current_raw_i})) * VW'(CUR_GAIN);
      cv_q  <= cg_q + VW'(CUR_OFFSET);
      cur_q <= cur_full[12:0];
    end
  end

  res_t res_s3;
  res_t res_out;

  assign res_s3 = '{fwd: pw_q[0], refl: pw_q[1], cur: cur_q, drv: pw_q[2]};

  atcswr_ratio u_ratio (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (pv3_q),
    .res_i   (res_s3),
    .valid_o (swr_valid),
    .res_o   (res_out),
    .swr_o   (swr_ratio_o)
  );

  assign out_valid_o       = swr_valid;
  assign forward_power_o   = res_out.fwd;
  assign reflected_power_o = res_out.refl;
  assign supply_current_o  = res_out.cur;
  assign drive_power_o     = res_out.drv;

endmodule
